[src/csv_pkg.sv]
// ----------------------------------------------------------------------------
// csv_pkg
// shared types and constants of the cylinder support vote block
// ----------------------------------------------------------------------------
package csv_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AXIAL,
        ST_TCHK,
        ST_RADIAL,
        ST_ZCHK,
        ST_NORM,
        ST_DOT,
        ST_ROOT,
        ST_COS,
        ST_DECIDE,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        REG_AXIS_X   = 3'd0,
        REG_AXIS_Y   = 3'd1,
        REG_AXIS_Z   = 3'd2,
        REG_CENTER_X = 3'd3,
        REG_CENTER_Y = 3'd4,
        REG_CENTER_Z = 3'd5,
        REG_RADIUS   = 3'd6,
        REG_MAX_DIST = 3'd7
    } reg_index_t;

    localparam int MUL_W = 32;
    localparam int PROD_W = 64;
    localparam int RAD_W = 56;
    localparam int ROOT_W = 27;
    localparam int ROOT_STEPS = 28;
    localparam logic signed [43:0] HALF_HEIGHT_Q22 = 44'sd419430400;
    localparam logic signed [27:0] SHELL_Q8 = 28'sd25600;
    localparam logic [13:0] COS45_Q14 = 14'd11585;

endpackage

[src/csv_mul.sv]
// ----------------------------------------------------------------------------
// csv_mul
// shared signed multiplier used by the sequencer
// ----------------------------------------------------------------------------
module csv_mul (
    input  logic signed [csv_pkg::MUL_W-1:0]  op_a,
    input  logic signed [csv_pkg::MUL_W-1:0]  op_b,
    output logic signed [csv_pkg::PROD_W-1:0] prod
);

    localparam int PROD_W = csv_pkg::PROD_W;

    assign prod = PROD_W'(op_a) * PROD_W'(op_b);

endmodule

[src/csv_isqrt.sv]
// ----------------------------------------------------------------------------
// csv_isqrt
// iterative integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module csv_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [csv_pkg::RAD_W-1:0]     radicand,
    output logic                          done,
    output logic [csv_pkg::ROOT_W-1:0]    root
);

    logic [csv_pkg::RAD_W-1:0] rem_reg, res_reg, bit_reg;
    logic [4:0] cnt_reg;
    logic busy_reg, done_reg;
    logic [csv_pkg::RAD_W-1:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 5'(csv_pkg::ROOT_STEPS - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            cnt_reg <= cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= radicand;
            res_reg <= '0;
            bit_reg <= csv_pkg::RAD_W'(1) << (2 * (csv_pkg::ROOT_STEPS - 1));
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[csv_pkg::ROOT_W-1:0];

endmodule

[src/cylinder_support_vote.sv]
// ----------------------------------------------------------------------------
// cylinder_support_vote
// scores one point and normal against a configured cylinder
// ----------------------------------------------------------------------------
// One point is taken at a time; in_ready is low while it is scored. When
// all tests run, a point passes through three multiplies each for the
// axial offset, radial vector, squared distance and normal dot product on
// one shared multiplier, then the bit-serial square root, which overlaps
// the dot product, and one multiply for the angle bound; the axial or z
// test can end it early. in_ready returns the cycle after the vote
// transfer. A running saturating vote sum is kept and cleared after the
// point marked last.
module cylinder_support_vote #(
    parameter int MAX_POINTS = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [23:0] point_x,
    input  logic signed [23:0] point_y,
    input  logic signed [23:0] point_z,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    input  logic signed [15:0] normal_z,
    input  logic               last_point,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [1:0]  vote
);

    localparam int LIMIT = (MAX_POINTS < 131071) ? MAX_POINTS : 131071;
    localparam logic signed [17:0] SUM_LIMIT = 18'(LIMIT);

    localparam int MW = csv_pkg::MUL_W;

    csv_pkg::state_t state_reg, state_next;
    logic [1:0] k_reg, k_next;

    logic signed [15:0] axis_reg [3];
    logic signed [23:0] center_reg [3];
    logic [22:0] radius_reg, max_dist_reg;

    logic signed [24:0] d_reg [3];
    logic signed [15:0] n_reg [3];
    logic signed [26:0] ps_reg [3];
    logic signed [43:0] t_reg;
    logic [csv_pkg::RAD_W-1:0] s2_reg;
    logic signed [44:0] dot_reg;
    logic [40:0] cos_reg;
    logic last_reg;
    logic signed [1:0] vote_reg;
    logic signed [17:0] sum_reg;

    logic signed [MW-1:0] op_a, op_b;
    logic signed [csv_pkg::PROD_W-1:0] prod, rnd;
    logic finish;
    logic signed [1:0] vote_val;
    logic [csv_pkg::ROOT_W-1:0] radial_dist;
    logic root_start, root_done;

    logic signed [27:0] diff, lo;
    logic signed [44:0] mag;
    logic signed [18:0] sum_add;

    csv_mul u_mul (
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    csv_isqrt u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (s2_reg),
        .done     (root_done),
        .root     (radial_dist)
    );

    assign root_start = (state_reg == csv_pkg::ST_DOT) && (k_reg == 2'd0);
    assign rnd = (prod + (csv_pkg::PROD_W'(1) <<< 27)) >>> 28;

    assign diff = 28'($signed({1'b0, radial_dist})) - 28'($signed({1'b0, radius_reg}));
    assign lo = diff[27] ? -diff : diff;
    assign mag = dot_reg[44] ? -dot_reg : dot_reg;

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            csv_pkg::ST_AXIAL:
            begin
                op_a = MW'(axis_reg[k_reg]);
                op_b = MW'(d_reg[k_reg]);
            end
            csv_pkg::ST_RADIAL:
            begin
                op_a = MW'($signed(t_reg[29:0]));
                op_b = MW'(axis_reg[k_reg]);
            end
            csv_pkg::ST_NORM:
            begin
                op_a = MW'(ps_reg[k_reg]);
                op_b = MW'(ps_reg[k_reg]);
            end
            csv_pkg::ST_DOT:
            begin
                op_a = MW'(ps_reg[k_reg]);
                op_b = MW'(n_reg[k_reg]);
            end
            csv_pkg::ST_COS:
            begin
                op_a = MW'($signed({1'b0, radial_dist}));
                op_b = MW'($signed({1'b0, csv_pkg::COS45_Q14}));
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        k_next = k_reg;
        finish = 1'b0;
        vote_val = 2'sd0;
        unique case (state_reg)
            csv_pkg::ST_IDLE:
            begin
                k_next = 2'd0;
                if (in_valid)
                begin
                    state_next = csv_pkg::ST_AXIAL;
                end
            end
            csv_pkg::ST_AXIAL, csv_pkg::ST_RADIAL, csv_pkg::ST_NORM, csv_pkg::ST_DOT:
            begin
                k_next = (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                if (k_reg == 2'd2)
                begin
                    priority case (state_reg)
                        csv_pkg::ST_AXIAL:  state_next = csv_pkg::ST_TCHK;
                        csv_pkg::ST_RADIAL: state_next = csv_pkg::ST_ZCHK;
                        csv_pkg::ST_NORM:   state_next = csv_pkg::ST_DOT;
                        default:            state_next = csv_pkg::ST_ROOT;
                    endcase
                end
            end
            csv_pkg::ST_TCHK:
            begin
                if (t_reg > csv_pkg::HALF_HEIGHT_Q22 || t_reg < -csv_pkg::HALF_HEIGHT_Q22)
                begin
                    finish = 1'b1;
                    state_next = csv_pkg::ST_OUT;
                end
                else
                begin
                    state_next = csv_pkg::ST_RADIAL;
                end
            end
            csv_pkg::ST_ZCHK:
            begin
                if (ps_reg[2] < 0)
                begin
                    finish = 1'b1;
                    state_next = csv_pkg::ST_OUT;
                end
                else
                begin
                    state_next = csv_pkg::ST_NORM;
                end
            end
            csv_pkg::ST_ROOT:
            begin
                if (root_done)
                begin
                    state_next = csv_pkg::ST_COS;
                end
            end
            csv_pkg::ST_COS:
            begin
                state_next = csv_pkg::ST_DECIDE;
            end
            csv_pkg::ST_DECIDE:
            begin
                finish = 1'b1;
                state_next = csv_pkg::ST_OUT;
                if ((28'(radial_dist) > 28'(radius_reg) + 28'(max_dist_reg)) &&
                    (diff < csv_pkg::SHELL_Q8))
                begin
                    vote_val = -2'sd1;
                end
                else if ((lo < 28'($signed({1'b0, max_dist_reg}))) &&
                         (mag > 45'($signed({1'b0, cos_reg}))))
                begin
                    vote_val = 2'sd1;
                end
            end
            csv_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = csv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = csv_pkg::ST_IDLE;
            end
        endcase
    end

    assign sum_add = 19'(sum_reg) + 19'(vote_val);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csv_pkg::ST_IDLE;
            k_reg <= 2'd0;
            sum_reg <= '0;
            axis_reg[0] <= '0;
            axis_reg[1] <= 16'sd16384;
            axis_reg[2] <= '0;
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            radius_reg <= '0;
            max_dist_reg <= 23'd5120;
        end
        else
        begin
            state_reg <= state_next;
            k_reg <= k_next;
            if (finish)
            begin
                if (last_reg)
                begin
                    sum_reg <= '0;
                end
                else if (sum_add > 19'(SUM_LIMIT))
                begin
                    sum_reg <= SUM_LIMIT;
                end
                else if (sum_add < -19'(SUM_LIMIT))
                begin
                    sum_reg <= -SUM_LIMIT;
                end
                else
                begin
                    sum_reg <= sum_add[17:0];
                end
            end
            if (cfg_we)
            begin
                unique case (csv_pkg::reg_index_t'(cfg_index))
                    csv_pkg::REG_AXIS_X:   axis_reg[0] <= cfg_data[15:0];
                    csv_pkg::REG_AXIS_Y:   axis_reg[1] <= cfg_data[15:0];
                    csv_pkg::REG_AXIS_Z:   axis_reg[2] <= cfg_data[15:0];
                    csv_pkg::REG_CENTER_X: center_reg[0] <= cfg_data;
                    csv_pkg::REG_CENTER_Y: center_reg[1] <= cfg_data;
                    csv_pkg::REG_CENTER_Z: center_reg[2] <= cfg_data;
                    csv_pkg::REG_RADIUS:   radius_reg <= cfg_data[22:0];
                    csv_pkg::REG_MAX_DIST: max_dist_reg <= cfg_data[22:0];
                    default:               radius_reg <= radius_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            vote_reg <= vote_val;
        end
        unique case (state_reg)
            csv_pkg::ST_IDLE:
            begin
                d_reg[0] <= 25'(point_x) - 25'(center_reg[0]);
                d_reg[1] <= 25'(point_y) - 25'(center_reg[1]);
                d_reg[2] <= 25'(point_z) - 25'(center_reg[2]);
                n_reg[0] <= normal_x;
                n_reg[1] <= normal_y;
                n_reg[2] <= normal_z;
                last_reg <= last_point;
                t_reg <= '0;
                s2_reg <= '0;
                dot_reg <= '0;
            end
            csv_pkg::ST_AXIAL:  t_reg <= t_reg + prod[43:0];
            csv_pkg::ST_RADIAL: ps_reg[k_reg] <= 27'(d_reg[k_reg]) - rnd[26:0];
            csv_pkg::ST_NORM:   s2_reg <= s2_reg + prod[csv_pkg::RAD_W-1:0];
            csv_pkg::ST_DOT:    dot_reg <= dot_reg + prod[44:0];
            csv_pkg::ST_COS:    cos_reg <= prod[40:0];
            default:            last_reg <= last_reg;
        endcase
    end

    assign in_ready = (state_reg == csv_pkg::ST_IDLE);
    assign out_valid = (state_reg == csv_pkg::ST_OUT);
    assign vote = vote_reg;

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking regression of the cylinder support vote block
// ----------------------------------------------------------------------------
// Points and normals are driven over a valid/ready channel in bursts, votes
// are taken back under a random stall pattern and compared in order with an
// in-bench vote predictor. A directed table covers the axial and z cut-offs,
// the outer shell, supporting and non-supporting angles and the field
// extremes; random sets of points near the configured cylinder follow, over
// several register settings.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SUM_CAP = 65536;
    localparam longint HALF_H = longint'(100) << 22;
    localparam longint SHELL = longint'(100) << 8;
    localparam longint COS45 = 11585;
    localparam longint CYCLE_LIMIT = 1500000;

    typedef struct {
        logic signed [23:0] px, py, pz;
        logic signed [15:0] nx, ny, nz;
        logic               last;
        bit                 typed;
        logic signed [1:0]  vote;
    } point_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    csv_pkg::reg_index_t   cfg_index = csv_pkg::REG_AXIS_X;
    logic [23:0]           cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic signed [23:0]    point_x = '0, point_y = '0, point_z = '0;
    logic signed [15:0]    normal_x = '0, normal_y = '0, normal_z = '0;
    logic                  last_point = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic signed [1:0]     vote;

    longint ax, ay, az, cx, cy, cz, rad, mdist, vote_sum;
    logic signed [1:0] expected_votes[$];
    int errors = 0;
    longint cycles = 0;
    bit stall_free = 0;

    cylinder_support_vote dut (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_ready,
        .point_x, .point_y, .point_z, .normal_x, .normal_y, .normal_z,
        .last_point, .out_valid, .out_ready, .vote
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("cylinder_support_vote regression: fail");
            $finish;
        end
    end

    function automatic longint isqrt(longint unsigned s);
        longint unsigned r = 0;
        longint unsigned b = longint'(1) << 62;
        while (b > s)
            b >>= 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // round to nearest with ties toward +inf, arithmetic shift
    function automatic longint round28(longint x);
        return (x + (longint'(1) << 27)) >>> 28;
    endfunction

    function automatic logic signed [1:0] cylinder_vote(point_row_t r);
        longint d[3], ps[3], a[3], n[3];
        longint t, radial_dist, lo, dotp;
        longint unsigned s2;
        a = '{ax, ay, az};
        n = '{longint'(r.nx), longint'(r.ny), longint'(r.nz)};
        d[0] = longint'(r.px) - cx;
        d[1] = longint'(r.py) - cy;
        d[2] = longint'(r.pz) - cz;
        t = a[0] * d[0] + a[1] * d[1] + a[2] * d[2];
        if (t > HALF_H || t < -HALF_H)
            return 2'sd0;
        s2 = 0;
        dotp = 0;
        for (int i = 0; i < 3; i++)
            ps[i] = d[i] - round28(t * a[i]);
        if (ps[2] < 0)
            return 2'sd0;
        for (int i = 0; i < 3; i++)
        begin
            s2 += longint'(ps[i] * ps[i]);
            dotp += ps[i] * n[i];
        end
        radial_dist = isqrt(s2);
        if (radial_dist > rad + mdist && radial_dist - rad < SHELL)
            return -2'sd1;
        lo = radial_dist - rad;
        if (lo < 0)
            lo = -lo;
        if (dotp < 0)
            dotp = -dotp;
        if (lo < mdist && dotp > COS45 * radial_dist)
            return 2'sd1;
        return 2'sd0;
    endfunction

    task automatic write_reg(csv_pkg::reg_index_t idx, longint value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[23:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            csv_pkg::REG_AXIS_X:   ax = longint'(signed'(value[15:0]));
            csv_pkg::REG_AXIS_Y:   ay = longint'(signed'(value[15:0]));
            csv_pkg::REG_AXIS_Z:   az = longint'(signed'(value[15:0]));
            csv_pkg::REG_CENTER_X: cx = longint'(signed'(value[23:0]));
            csv_pkg::REG_CENTER_Y: cy = longint'(signed'(value[23:0]));
            csv_pkg::REG_CENTER_Z: cz = longint'(signed'(value[23:0]));
            csv_pkg::REG_RADIUS:   rad = longint'(value[22:0]);
            csv_pkg::REG_MAX_DIST: mdist = longint'(value[22:0]);
        endcase
    endtask

    task automatic set_cylinder(longint x, longint y, longint z, longint ccx,
                                longint ccy, longint ccz, longint r, longint m);
        write_reg(csv_pkg::REG_AXIS_X, x);
        write_reg(csv_pkg::REG_AXIS_Y, y);
        write_reg(csv_pkg::REG_AXIS_Z, z);
        write_reg(csv_pkg::REG_CENTER_X, ccx);
        write_reg(csv_pkg::REG_CENTER_Y, ccy);
        write_reg(csv_pkg::REG_CENTER_Z, ccz);
        write_reg(csv_pkg::REG_RADIUS, r);
        write_reg(csv_pkg::REG_MAX_DIST, m);
    endtask

    task automatic drain_votes();
        while (expected_votes.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    // sender: one transfer, valid held until accepted
    task automatic send_point(point_row_t r);
        logic signed [1:0] v;
        v = cylinder_vote(r);
        if (r.typed && v != r.vote)
        begin
            $error("table vote expected %0d predicted %0d", r.vote, v);
            errors++;
        end
        in_valid <= 1'b1;
        point_x <= r.px; point_y <= r.py; point_z <= r.pz;
        normal_x <= r.nx; normal_y <= r.ny; normal_z <= r.nz;
        last_point <= r.last;
        do
            @(posedge clk);
        while (!in_ready);
        expected_votes.push_back(r.typed ? r.vote : v);
        vote_sum += v;
        if (vote_sum > SUM_CAP) vote_sum = SUM_CAP;
        if (vote_sum < -SUM_CAP) vote_sum = -SUM_CAP;
        if (r.last) vote_sum = 0;
        if ($urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge clk);
        end
    endtask

    function automatic point_row_t mk(longint x, longint y, longint z, longint a,
                                      longint b, longint c, bit l = 0,
                                      bit typed = 0, int v = 0);
        point_row_t r;
        r.px = 24'(x); r.py = 24'(y); r.pz = 24'(z);
        r.nx = 16'(a); r.ny = 16'(b); r.nz = 16'(c);
        r.last = l; r.typed = typed; r.vote = 2'(v);
        return r;
    endfunction

    // point near the cylinder with a roughly radial normal, or in one mode of ten a fully random point
    function automatic point_row_t near_point();
        longint x, y, z, sx, sz;
        int mode;
        mode = $urandom_range(0, 9);
        sx = $urandom_range(0, 1) ? 1 : -1;
        x = cx + sx * longint'($urandom_range(0, rad + mdist * 2 + 30000));
        z = cz + longint'($urandom_range(0, rad + 30000)) - 2000;
        y = cy + longint'($urandom_range(0, 60000)) - 30000;
        if (mode == 0)
            return mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom_range(0, 15) == 0);
        return mk(x, y, z, sx * longint'($urandom_range(8000, 16384)),
                  longint'($urandom_range(0, 8000)) - 4000,
                  longint'($urandom_range(0, 16384)) - 4000,
                  $urandom_range(0, 31) == 0);
    endfunction

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (expected_votes.size() == 0)
            begin
                $error("vote transfer with none expected, actual %0d", vote);
                errors++;
            end
            else
            begin
                logic signed [1:0] e;
                e = expected_votes.pop_front();
                if (vote !== e)
                begin
                    $error("vote expected %0d actual %0d", e, vote);
                    errors++;
                end
            end
        end
        out_ready <= stall_free || (cycles % 23) > 6 || $urandom_range(0, 1);
    end

    initial
    begin
        point_row_t rows[$];
        ax = 0; ay = 16384; az = 0; cx = 0; cy = 0; cz = 0;
        rad = 0; mdist = 5120; vote_sum = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // reset settings: radius 0, tolerance 20 mm, axis y
        rows.push_back(mk(0, 0, 0, 16384, 0, 0, 0, 1, 0));
        rows.push_back(mk(0, 25601, 1000, 0, 0, 16384, 0, 1, 0));
        rows.push_back(mk(0, -25601, 1000, 0, 0, 16384, 0, 1, 0));
        rows.push_back(mk(0, 0, -1, 0, 0, 16384, 0, 1, 0));
        rows.push_back(mk(0, 0, 2560, 0, 0, 16384, 0, 1, 1));
        rows.push_back(mk(0, 0, 2560, 16384, 0, 0, 0, 1, 0));
        rows.push_back(mk(0, 0, 10240, 0, 0, 16384, 0, 1, -1));
        rows.push_back(mk(0, 0, 30000, 0, 0, 16384, 0, 1, 0));
        rows.push_back(mk(0, 0, 2560, 0, 0, -16384, 1, 1, 1));
        rows.push_back(mk(-8388608, -8388608, -8388608, -16384, -16384, -16384));
        rows.push_back(mk(8388607, 8388607, 8388607, 16384, 16384, 16384));
        rows.push_back(mk(0, 25600, 2560, 0, 0, 16384));
        rows.push_back(mk(0, 0, 5120, 0, 0, 16384));
        rows.push_back(mk(0, 0, 1000, 32767, -32768, 32767, 1));
        foreach (rows[i])
            send_point(rows[i]);
        in_valid <= 1'b0;
        drain_votes();
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_cylinder(0, 16384, 0, 0, 0, 0, 5120, 512);
                1: set_cylinder(16384, 0, 0, 1000, -2000, 300, 12800, 2560);
                2: set_cylinder(0, 0, 16384, -5000, 5000, 0, 0, 0);
                3: set_cylinder(11585, 11585, 0, 0, 0, 0, 7680, 1024);
                4: set_cylinder(-16384, 16384, 16384, 8388607, -8388608,
                                -8388608, 8388607, 8388607);
                default: set_cylinder($urandom, $urandom, $urandom, $urandom,
                                      $urandom, $urandom, $urandom, $urandom);
            endcase
            stall_free = (phase == 2);
            repeat (250)
                send_point(near_point());
            in_valid <= 1'b0;
            drain_votes();
        end
        write_reg(csv_pkg::REG_MAX_DIST, 5120);
        if (errors == 0)
            $display("cylinder_support_vote regression: pass");
        else
            $display("cylinder_support_vote regression: fail");
        $finish;
    end
endmodule
